>>> src/rrs_pkg.sv
`timescale 1ns / 1ps
package rrs_pkg;

  localparam int DEF_MAX_PROCESSES = 16;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_SWITCH = 3'd1;
  localparam logic [2:0] OP_WAKE   = 3'd2;
  localparam logic [2:0] OP_SLEEP  = 3'd3;
  localparam logic [2:0] OP_REMOVE = 3'd4;
  localparam logic [2:0] OP_FIND   = 3'd5;

  localparam logic [1:0] STAT_OK          = 2'd0;
  localparam logic [1:0] STAT_READY_FULL  = 2'd1;
  localparam logic [1:0] STAT_SLEEP_FULL  = 2'd2;

  localparam logic [1:0] LOC_NONE  = 2'd0;
  localparam logic [1:0] LOC_READY = 2'd1;
  localparam logic [1:0] LOC_SLEEP = 2'd2;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] pid;
    logic [15:0] seconds;
    logic [31:0] now_time;
    logic [15:0] current_pid;
    logic        current_valid;
  } in_item_t;

  typedef struct packed {
    logic [15:0] selected_pid;
    logic [1:0]  status;
    logic [1:0]  location;
    logic [4:0]  woken_count;
    logic [4:0]  ready_count;
    logic [4:0]  sleep_count;
  } out_item_t;

endpackage

>>> src/rrs_in_if.sv
`timescale 1ns / 1ps
interface rrs_in_if;
  logic              valid;
  logic              ready;
  rrs_pkg::in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> src/rrs_out_if.sv
`timescale 1ns / 1ps
interface rrs_out_if;
  logic               valid;
  logic               ready;
  rrs_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> src/round_robin_scheduler_with_sleep.sv
`timescale 1ns / 1ps
// Channel   Dir  Beat payload
// in_ch     in   operation, pid, seconds, now_time, current_pid, current_valid
// out_ch    out  selected_pid, status, location, woken_count, ready_count, sleep_count
// cfg       in   idle_pid write (cfg_we, cfg_wdata)
//
// One item at a time. Add and the unused codes go straight to the done state. The other
// operations walk their list in the RAM with a read step and then a compact-and-write-back
// step per entry; remove, and a find that misses the ready queue, walk both lists.
// Reset clears the fills, idle_pid and the output valid; there is no clearing pass over the RAMs.
// A finished result waits in the output register; the next beat is taken meanwhile.
module round_robin_scheduler_with_sleep #(
  parameter int MAX_PROCESSES = rrs_pkg::DEF_MAX_PROCESSES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  rrs_in_if.sink      in_ch,
  rrs_out_if.source   out_ch
);

  localparam int AW = $clog2(MAX_PROCESSES);
  localparam int CW = $clog2(MAX_PROCESSES + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_PROCESSES);

  typedef enum logic [1:0] {S_IDLE, S_RD, S_PROC, S_DONE} state_t;

  state_t      state;
  logic [15:0] idle_pid;
  logic [2:0]  op;
  logic [15:0] pid;
  logic [31:0] now_time;
  logic [31:0] wake_at;
  logic        in_sleep;
  logic [CW-1:0] idx, wr, rfill, sfill, woken;
  logic        hit;
  logic [15:0] selected;
  logic [1:0]  status, location;
  logic        out_valid;
  rrs_pkg::out_item_t out_data;

  logic          r_we, s_we;
  logic [AW-1:0] r_waddr, s_waddr;
  logic [15:0]   r_wdata, r_rdata;
  logic [47:0]   s_wdata, s_rdata;

  logic [15:0] s_id;
  logic        r_match, s_match, due, drop, match;
  logic [CW-1:0] list_fill;
  logic        accept;
  logic        requeue;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.data = out_data;

  assign requeue = in_ch.data.current_valid && (in_ch.data.current_pid != idle_pid);

  assign s_id = s_rdata[47:32];
  assign r_match = (r_rdata == pid);
  assign s_match = (s_id == pid);
  assign due = (s_rdata[31:0] <= now_time);
  assign match = in_sleep ? s_match : r_match;
  assign list_fill = in_sleep ? sfill : rfill;

  always_comb begin
    drop = 1'b0;
    if (!in_sleep) begin
      case (op)
        rrs_pkg::OP_SWITCH: drop = (idx == '0);
        rrs_pkg::OP_SLEEP:  drop = r_match && !hit;
        rrs_pkg::OP_REMOVE: drop = r_match;
        default:            drop = 1'b0;
      endcase
    end else begin
      case (op)
        rrs_pkg::OP_WAKE:   drop = due;
        rrs_pkg::OP_REMOVE: drop = s_match && !hit;
        default:            drop = 1'b0;
      endcase
    end
  end

  always_comb begin
    r_we = 1'b0;
    r_waddr = rfill[AW-1:0];
    r_wdata = in_ch.data.pid;
    s_we = 1'b0;
    s_waddr = sfill[AW-1:0];
    s_wdata = {pid, wake_at};
    case (state)
      S_IDLE: begin
        if (accept && rfill < FULL) begin
          if (in_ch.data.operation == rrs_pkg::OP_ADD) begin
            r_we = 1'b1;
          end else if (in_ch.data.operation == rrs_pkg::OP_SWITCH && requeue) begin
            r_we = 1'b1;
            r_wdata = in_ch.data.current_pid;
          end
        end
      end
      S_RD: begin
        if (idx >= list_fill && !in_sleep && op == rrs_pkg::OP_SLEEP && sfill < FULL) begin
          s_we = 1'b1;
        end
      end
      S_PROC: begin
        // Kept entries slide down to the write index; it never passes the read index.
        if (!drop) begin
          if (in_sleep) begin
            s_we = 1'b1;
            s_waddr = wr[AW-1:0];
            s_wdata = s_rdata;
          end else begin
            r_we = 1'b1;
            r_waddr = wr[AW-1:0];
            r_wdata = r_rdata;
          end
        end else if (in_sleep && op == rrs_pkg::OP_WAKE && rfill < FULL) begin
          r_we = 1'b1;
          r_wdata = s_id;
        end
      end
      default: begin
      end
    endcase
  end

  rrs_ram #(.WIDTH(16), .DEPTH(MAX_PROCESSES)) u_ready_ram (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(idx[AW-1:0]), .rdata(r_rdata)
  );

  rrs_ram #(.WIDTH(48), .DEPTH(MAX_PROCESSES)) u_sleep_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(idx[AW-1:0]), .rdata(s_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idle_pid <= '0;
      rfill <= '0;
      sfill <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        idle_pid <= cfg_wdata;
      end
      if (out_valid && out_ch.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op <= in_ch.data.operation;
            pid <= in_ch.data.pid;
            now_time <= in_ch.data.now_time;
            wake_at <= in_ch.data.now_time + 32'(in_ch.data.seconds);
            selected <= (in_ch.data.operation == rrs_pkg::OP_SWITCH) ? idle_pid : 16'd0;
            location <= rrs_pkg::LOC_NONE;
            woken <= '0;
            hit <= 1'b0;
            idx <= '0;
            wr <= '0;
            in_sleep <= (in_ch.data.operation == rrs_pkg::OP_WAKE);
            case (in_ch.data.operation)
              rrs_pkg::OP_ADD: begin
                if (rfill < FULL) begin
                  rfill <= rfill + 1'b1;
                  status <= rrs_pkg::STAT_OK;
                end else begin
                  status <= rrs_pkg::STAT_READY_FULL;
                end
                state <= S_DONE;
              end
              rrs_pkg::OP_SWITCH: begin
                if (requeue && rfill < FULL) begin
                  rfill <= rfill + 1'b1;
                end
                status <= (requeue && rfill >= FULL) ? rrs_pkg::STAT_READY_FULL :
                                                       rrs_pkg::STAT_OK;
                state <= S_RD;
              end
              rrs_pkg::OP_WAKE, rrs_pkg::OP_SLEEP, rrs_pkg::OP_REMOVE,
              rrs_pkg::OP_FIND: begin
                status <= rrs_pkg::STAT_OK;
                state <= S_RD;
              end
              default: begin
                status <= rrs_pkg::STAT_OK;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_RD: begin
          if (idx < list_fill) begin
            state <= S_PROC;
          end else if (in_sleep) begin
            sfill <= wr;
            state <= S_DONE;
          end else begin
            rfill <= wr;
            if (op == rrs_pkg::OP_SLEEP) begin
              if (sfill < FULL) begin
                sfill <= sfill + 1'b1;
              end else begin
                status <= rrs_pkg::STAT_SLEEP_FULL;
              end
              state <= S_DONE;
            end else if (op == rrs_pkg::OP_REMOVE || (op == rrs_pkg::OP_FIND && !hit)) begin
              in_sleep <= 1'b1;
              idx <= '0;
              wr <= '0;
              hit <= 1'b0;
              state <= S_RD;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_PROC: begin
          idx <= idx + 1'b1;
          if (!drop) begin
            wr <= wr + 1'b1;
          end
          if (match && !hit) begin
            hit <= 1'b1;
            if (op == rrs_pkg::OP_FIND) begin
              location <= in_sleep ? rrs_pkg::LOC_SLEEP : rrs_pkg::LOC_READY;
            end
          end
          if (!in_sleep && op == rrs_pkg::OP_SWITCH && idx == '0) begin
            selected <= r_rdata;
          end
          if (in_sleep && op == rrs_pkg::OP_WAKE && due) begin
            if (rfill < FULL) begin
              rfill <= rfill + 1'b1;
              woken <= woken + 1'b1;
            end else begin
              status <= rrs_pkg::STAT_READY_FULL;
            end
          end
          state <= S_RD;
        end
        S_DONE: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            out_data.selected_pid <= selected;
            out_data.status <= status;
            out_data.location <= location;
            out_data.woken_count <= 5'(woken);
            out_data.ready_count <= 5'(rfill);
            out_data.sleep_count <= 5'(sfill);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_rfill_bound: assert property (@(posedge clk) disable iff (rst) rfill <= FULL)
    else $error("ready fill beyond depth");
  a_sfill_bound: assert property (@(posedge clk) disable iff (rst) sfill <= FULL)
    else $error("sleep fill beyond depth");
  a_compact_order: assert property (@(posedge clk) disable iff (rst)
      (state == S_PROC) |-> (wr <= idx && idx < list_fill))
    else $error("compaction write index passed read index");
  a_add_done: assert property (@(posedge clk) disable iff (rst)
      (accept && in_ch.data.operation == rrs_pkg::OP_ADD) |=> (state == S_DONE))
    else $error("add did not finish at once");

endmodule

>>> src/rrs_ram.sv
`timescale 1ns / 1ps
module rrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = rrs_pkg::DEF_MAX_PROCESSES
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> tb/round_robin_scheduler_with_sleep_tb.sv
`timescale 1ns / 1ps
module round_robin_scheduler_with_sleep_tb;

  localparam int DEPTH = rrs_pkg::DEF_MAX_PROCESSES;
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam int ITEM_CYCLES = 4 * DEPTH + 8;
  localparam int STALL_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  rrs_in_if  in_ch ();
  rrs_out_if out_ch ();

  round_robin_scheduler_with_sleep dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  // Scheduler state as the block should hold it.
  logic [15:0] idle_id;
  logic [15:0] run_q[$];
  logic [15:0] nap_ids[$];
  logic [31:0] nap_due[$];

  rrs_pkg::out_item_t expected_q[$];
  int        error_count;
  int        beats_checked;
  int        op_seen[8];
  int        drops_seen;
  int        src_idle_pct;
  int        sink_stall_pct;
  int        quiet_cycles;
  logic [31:0] clock_s;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic rrs_pkg::out_item_t schedule(input rrs_pkg::in_item_t it);
    rrs_pkg::out_item_t r;
    int        i;
    logic [31:0] due;
    r = '0;
    case (it.operation)
      rrs_pkg::OP_ADD: begin
        if (run_q.size() < DEPTH) run_q.insert(run_q.size(), it.pid);
        else r.status = rrs_pkg::STAT_READY_FULL;
      end
      rrs_pkg::OP_SWITCH: begin
        if (it.current_valid && it.current_pid != idle_id) begin
          if (run_q.size() < DEPTH) run_q.insert(run_q.size(), it.current_pid);
          else r.status = rrs_pkg::STAT_READY_FULL;
        end
        if (run_q.size() > 0) begin
          r.selected_pid = run_q[0];
          run_q.delete(0);
        end else begin
          r.selected_pid = idle_id;
        end
      end
      rrs_pkg::OP_WAKE: begin
        i = 0;
        while (i < nap_ids.size()) begin
          if (nap_due[i] <= it.now_time) begin
            if (run_q.size() < DEPTH) begin
              run_q.insert(run_q.size(), nap_ids[i]);
              r.woken_count = r.woken_count + 5'd1;
            end else begin
              r.status = rrs_pkg::STAT_READY_FULL;
            end
            nap_ids.delete(i);
            nap_due.delete(i);
          end else begin
            i++;
          end
        end
      end
      rrs_pkg::OP_SLEEP: begin
        due = it.now_time + {16'd0, it.seconds};
        for (i = 0; i < run_q.size(); i++) begin
          if (run_q[i] == it.pid) begin
            run_q.delete(i);
            break;
          end
        end
        if (nap_ids.size() < DEPTH) begin
          nap_ids.insert(nap_ids.size(), it.pid);
          nap_due.insert(nap_due.size(), due);
        end else begin
          r.status = rrs_pkg::STAT_SLEEP_FULL;
        end
      end
      rrs_pkg::OP_REMOVE: begin
        i = 0;
        while (i < run_q.size()) begin
          if (run_q[i] == it.pid) run_q.delete(i);
          else i++;
        end
        for (i = 0; i < nap_ids.size(); i++) begin
          if (nap_ids[i] == it.pid) begin
            nap_ids.delete(i);
            nap_due.delete(i);
            break;
          end
        end
      end
      rrs_pkg::OP_FIND: begin
        foreach (run_q[k]) if (r.location == rrs_pkg::LOC_NONE && run_q[k] == it.pid)
          r.location = rrs_pkg::LOC_READY;
        foreach (nap_ids[k]) if (r.location == rrs_pkg::LOC_NONE && nap_ids[k] == it.pid)
          r.location = rrs_pkg::LOC_SLEEP;
      end
      default: ;
    endcase
    r.ready_count = 5'(run_q.size());
    r.sleep_count = 5'(nap_ids.size());
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
    error_count++;
  endtask

  task automatic send_item(input rrs_pkg::in_item_t it);
    rrs_pkg::out_item_t e;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    e = schedule(it);
    expected_q.insert(expected_q.size(), e);
    op_seen[it.operation]++;
    if (e.status != rrs_pkg::STAT_OK) drops_seen++;
    @(negedge clk);
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (expected_q.size() > 0) @(negedge clk);
    repeat (ITEM_CYCLES) @(negedge clk);
  endtask

  task automatic set_idle_pid(input logic [15:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    idle_id = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic rrs_pkg::in_item_t item(input logic [2:0] op, input logic [15:0] id,
                                             input logic [15:0] secs,
                                             input logic [31:0] now,
                                             input logic [15:0] cur, input logic cv);
    rrs_pkg::in_item_t it;
    it.operation     = op;
    it.pid           = id;
    it.seconds       = secs;
    it.now_time      = now;
    it.current_pid   = cur;
    it.current_valid = cv;
    return it;
  endfunction

  // Small id pool so that find, remove and duplicates hit often.
  function automatic logic [15:0] pick_id();
    if ($urandom_range(99) < 80) return 16'($urandom_range(0, 7));
    if ($urandom_range(1) == 1) return idle_id;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic rrs_pkg::in_item_t random_item(input bit filling);
    rrs_pkg::in_item_t it;
    int       w;
    w = $urandom_range(99);
    if (filling) begin
      if (w < 40) it.operation = rrs_pkg::OP_ADD;
      else if (w < 63) it.operation = rrs_pkg::OP_SLEEP;
      else if (w < 73) it.operation = rrs_pkg::OP_SWITCH;
      else if (w < 83) it.operation = rrs_pkg::OP_WAKE;
      else if (w < 88) it.operation = rrs_pkg::OP_REMOVE;
      else if (w < 97) it.operation = rrs_pkg::OP_FIND;
      else it.operation = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
    end else begin
      if (w < 10) it.operation = rrs_pkg::OP_ADD;
      else if (w < 40) it.operation = rrs_pkg::OP_SWITCH;
      else if (w < 65) it.operation = rrs_pkg::OP_WAKE;
      else if (w < 80) it.operation = rrs_pkg::OP_REMOVE;
      else if (w < 94) it.operation = rrs_pkg::OP_FIND;
      else if (w < 97) it.operation = rrs_pkg::OP_SLEEP;
      else it.operation = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
    end
    it.pid = pick_id();
    it.seconds = ($urandom_range(9) == 0) ? 16'($urandom_range(0, 65535)) :
                                            16'($urandom_range(0, 20));
    clock_s = clock_s + $urandom_range(0, 8);
    if ($urandom_range(49) == 0) clock_s = 32'hFFFF_FFFF - $urandom_range(0, 40);
    it.now_time = ($urandom_range(29) == 0) ? $urandom() : clock_s;
    it.current_pid = ($urandom_range(2) == 0) ? idle_id : pick_id();
    it.current_valid = 1'($urandom_range(1));
    return it;
  endfunction

  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);

  always @(posedge clk) begin
    rrs_pkg::out_item_t got;
    rrs_pkg::out_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (expected_q.size() == 0) begin
        $display("unexpected result beat at %0t", $realtime);
        error_count++;
      end else begin
        want = expected_q[0];
        expected_q.delete(0);
        beats_checked++;
        if (got.selected_pid !== want.selected_pid)
          report_mismatch("selected_pid", int'(got.selected_pid), int'(want.selected_pid));
        if (got.status !== want.status)
          report_mismatch("status", int'(got.status), int'(want.status));
        if (got.location !== want.location)
          report_mismatch("location", int'(got.location), int'(want.location));
        if (got.woken_count !== want.woken_count)
          report_mismatch("woken_count", int'(got.woken_count), int'(want.woken_count));
        if (got.ready_count !== want.ready_count)
          report_mismatch("ready_count", int'(got.ready_count), int'(want.ready_count));
        if (got.sleep_count !== want.sleep_count)
          report_mismatch("sleep_count", int'(got.sleep_count), int'(want.sleep_count));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("watchdog expired at %0t", $realtime);
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_basic_ops;
    send_item(item(rrs_pkg::OP_SWITCH, 16'd0, 16'd0, 32'd0, 16'd9, 1'b0));
    send_item(item(rrs_pkg::OP_ADD, 16'h0000, 16'd0, 32'd0, 16'd0, 1'b0));
    send_item(item(rrs_pkg::OP_ADD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1));
    send_item(item(rrs_pkg::OP_FIND, 16'hFFFF, 16'd0, 32'd0, 16'd0, 1'b0));
    send_item(item(rrs_pkg::OP_FIND, 16'h1234, 16'd0, 32'd0, 16'd0, 1'b0));
    send_item(item(rrs_pkg::OP_SWITCH, 16'd0, 16'd0, 32'd0, 16'd5, 1'b1));
    send_item(item(rrs_pkg::OP_SWITCH, 16'd0, 16'd0, 32'd0, idle_id, 1'b1));
    // Wake time wraps past the top of the 32-bit clock.
    send_item(item(rrs_pkg::OP_SLEEP, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFF0, 16'd0, 1'b0));
    send_item(item(rrs_pkg::OP_FIND, 16'hFFFF, 16'd0, 32'd0, 16'd0, 1'b0));
    send_item(item(rrs_pkg::OP_WAKE, 16'd0, 16'd0, 32'd0, 16'd0, 1'b0));
    send_item(item(rrs_pkg::OP_WAKE, 16'd0, 16'd0, 32'hFFFF_FFFF, 16'd0, 1'b0));
    send_item(item(rrs_pkg::OP_SLEEP, 16'd5, 16'd0, 32'd100, 16'd0, 1'b0));
    send_item(item(rrs_pkg::OP_REMOVE, 16'd5, 16'd0, 32'd0, 16'd0, 1'b0));
    send_item(item(rrs_pkg::OP_ADD, 16'd7, 16'd0, 32'd0, 16'd0, 1'b0));
    send_item(item(rrs_pkg::OP_ADD, 16'd7, 16'd0, 32'd0, 16'd0, 1'b0));
    send_item(item(rrs_pkg::OP_FIND, 16'd7, 16'd0, 32'd0, 16'd0, 1'b0));
    send_item(item(rrs_pkg::OP_REMOVE, 16'd7, 16'd0, 32'd0, 16'd0, 1'b0));
    send_item(item(OP_SPARE_A, 16'd1, 16'd1, 32'd1, 16'd1, 1'b1));
    send_item(item(OP_SPARE_B, 16'd2, 16'd2, 32'd2, 16'd2, 1'b1));
  endtask

  task automatic test_full_lists;
    for (int i = 0; i <= DEPTH; i++)
      send_item(item(rrs_pkg::OP_ADD, 16'(i), 16'd0, 32'd0, 16'd0, 1'b0));
    send_item(item(rrs_pkg::OP_SWITCH, 16'd0, 16'd0, 32'd0, 16'd99, 1'b1));
    send_item(item(rrs_pkg::OP_ADD, 16'd50, 16'd0, 32'd0, 16'd0, 1'b0));
    for (int i = 0; i <= DEPTH; i++)
      send_item(item(rrs_pkg::OP_SLEEP, 16'(200 + i), 16'd0, 32'd10, 16'd0, 1'b0));
    // Ready queue is full again, so due sleepers are dropped.
    for (int i = 0; i < 4; i++)
      send_item(item(rrs_pkg::OP_ADD, 16'(300 + i), 16'd0, 32'd0, 16'd0, 1'b0));
    send_item(item(rrs_pkg::OP_WAKE, 16'd0, 16'd0, 32'd10, 16'd0, 1'b0));
    while (run_q.size() > 0 || nap_ids.size() > 0) begin
      if (run_q.size() > 0)
        send_item(item(rrs_pkg::OP_REMOVE, run_q[0], 16'd0, 32'd0, 16'd0, 1'b0));
      else
        send_item(item(rrs_pkg::OP_REMOVE, nap_ids[0], 16'd0, 32'd0, 16'd0, 1'b0));
    end
  endtask

  task automatic test_random(input int n, input int src_pct, input int sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    for (int i = 0; i < n; i++)
      send_item(random_item(((i / 40) % 2) == 0));
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    drops_seen = 0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    clock_s = '0;
    idle_id = '0;
    foreach (op_seen[k]) op_seen[k] = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_basic_ops();
    test_full_lists();
    set_idle_pid(16'hFFFF);
    test_basic_ops();
    test_random(140, 0, 0);
    set_idle_pid(16'd3);
    test_random(140, 72, 0);
    set_idle_pid(16'd0);
    test_random(140, 0, 72);
    set_idle_pid(16'h8001);
    test_random(140, 36, 36);
    drain();

    $display("checked %0d result beats: add %0d switch %0d wake %0d sleep %0d remove %0d",
             beats_checked, op_seen[rrs_pkg::OP_ADD], op_seen[rrs_pkg::OP_SWITCH],
             op_seen[rrs_pkg::OP_WAKE], op_seen[rrs_pkg::OP_SLEEP],
             op_seen[rrs_pkg::OP_REMOVE]);
    $display("find %0d, unused codes %0d, dropped on a full list %0d, mismatches %0d",
             op_seen[rrs_pkg::OP_FIND], op_seen[OP_SPARE_A] + op_seen[OP_SPARE_B],
             drops_seen, error_count);
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
src/rrs_pkg.sv
src/rrs_in_if.sv
src/rrs_out_if.sv
src/rrs_ram.sv
src/round_robin_scheduler_with_sleep.sv
tb/round_robin_scheduler_with_sleep_tb.sv
